// File: hdl/asp_pkg.sv
`default_nettype none

package asp_pkg;

    // fixed field widths of the channels and the config register
    localparam int NCFG_W        = 6;
    localparam int WANT_W        = 7;
    localparam int POS_W         = 6;
    localparam int S_TDATA_W     = 8;
    localparam int M_TDATA_W     = 16;
    localparam int M_TUSER_W     = 2;
    localparam int N_ITEMS_RESET = 4;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ITER,
        ST_LOOK,
        ST_CMP,
        ST_SWAP_A,
        ST_SWAP_B,
        ST_SWAP_W,
        ST_OUT
    } asp_state_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic take_req;
        logic load_m;
        logic look;
        logic step;
        logic swap_rd;
        logic swap_a;
        logic swap_b;
        logic swap_w;
        logic set_exh;
        logic out_none;
    } asp_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic req_bad;
        logic exhausted;
        logic found;
        logic m_is_two;
        logic out_last;
    } asp_sts_t;

endpackage

`default_nettype wire

// File: hdl/asp_datapath.sv
`default_nettype none

module asp_datapath #(
    parameter int MAX_ITEMS = 32,
    parameter int MAX_PAIRS = 64
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_wr_en,
    input  wire logic [asp_pkg::NCFG_W-1:0]  cfg_wr_data,
    input  wire logic                        s_restart,
    input  wire logic [asp_pkg::WANT_W-1:0]  s_pairs_wanted,
    input  wire asp_pkg::asp_cmd_t           cmd,
    output asp_pkg::asp_sts_t                sts,
    output logic      [asp_pkg::POS_W-1:0]   out_first,
    output logic      [asp_pkg::POS_W-1:0]   out_second,
    output logic                             out_pair_valid,
    output logic                             out_last,
    output logic                             out_more
);

    localparam int DEPTH   = MAX_ITEMS + 2;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(MAX_PAIRS + 1);
    localparam int RESET_N = (asp_pkg::N_ITEMS_RESET > MAX_ITEMS) ? MAX_ITEMS
                                                                   : asp_pkg::N_ITEMS_RESET;

    // config and request registers
    logic [asp_pkg::NCFG_W-1:0] n_items_reg;
    logic [IDX_W-1:0]           n_reg;
    logic [CNT_W-1:0]           want_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic [IDX_W-1:0]           fill_top_reg;
    logic                       exh_reg;

    // walk and swap registers
    logic [IDX_W-1:0]           m_reg;
    logic [IDX_W-1:0]           wm_reg;
    logic                       dir_m_reg;
    logic [IDX_W-1:0]           look_reg;
    logic [IDX_W-1:0]           vb_reg;
    logic [IDX_W-1:0]           va_reg;

    // result registers
    logic [asp_pkg::POS_W-1:0]  out_first_reg;
    logic [asp_pkg::POS_W-1:0]  out_second_reg;
    logic                       out_pv_reg;
    logic                       out_last_reg;
    logic                       out_more_reg;

    // memories: permutation, inverse, direction (1 = up, 0 = down)
    logic [IDX_W-1:0] value_mem [DEPTH];
    logic [IDX_W-1:0] where_mem [DEPTH];
    logic             dir_mem   [DEPTH];

    logic [DEPTH-1:0] value_vld_reg;
    logic [DEPTH-1:0] where_vld_reg;
    logic [DEPTH-1:0] dir_vld_reg;

    logic [IDX_W-1:0] value_rdata_reg;
    logic [IDX_W-1:0] value_raddr_reg;
    logic             value_rvld_reg;
    logic [IDX_W-1:0] where_rdata_reg;
    logic [IDX_W-1:0] walk_raddr_reg;
    logic             where_rvld_reg;
    logic             dir_rdata_reg;
    logic             dir_rvld_reg;

    logic [IDX_W-1:0] n_act;
    logic [CNT_W-1:0] want_sat;
    logic             req_bad;
    logic             restart_load;

    logic             value_re;
    logic [IDX_W-1:0] value_raddr;
    logic             value_we;
    logic [IDX_W-1:0] value_waddr;
    logic [IDX_W-1:0] value_wdata;
    logic             where_re;
    logic             dir_re;
    logic [IDX_W-1:0] walk_raddr;
    logic             where_we;
    logic [IDX_W-1:0] where_waddr;
    logic [IDX_W-1:0] where_wdata;

    logic [IDX_W-1:0] value_rd;
    logic [IDX_W-1:0] where_rd;
    logic             dir_rd;
    logic [IDX_W-1:0] look_calc;

    // request decode with saturation
    always_comb begin
        if (int'(n_items_reg) > MAX_ITEMS) begin
            n_act = IDX_W'(MAX_ITEMS);
        end else begin
            n_act = IDX_W'(n_items_reg);
        end
        if (int'(s_pairs_wanted) > MAX_PAIRS) begin
            want_sat = CNT_W'(MAX_PAIRS);
        end else begin
            want_sat = CNT_W'(s_pairs_wanted);
        end
        req_bad      = (n_items_reg < 6'd2) || (s_pairs_wanted == '0);
        restart_load = cmd.take_req && !req_bad && s_restart;
    end

    // read data, entries never written since the last reload read as identity (value entry 0 as the sentinel)
    always_comb begin
        if (value_rvld_reg) begin
            value_rd = value_rdata_reg;
        end else if (value_raddr_reg == '0) begin
            value_rd = fill_top_reg;
        end else begin
            value_rd = value_raddr_reg;
        end
        where_rd = where_rvld_reg ? where_rdata_reg : walk_raddr_reg;
        dir_rd   = dir_rvld_reg ? dir_rdata_reg : 1'b0;
    end

    // neighbour position in the element's direction, clamped to the array
    always_comb begin
        if (dir_rd) begin
            look_calc = (where_rd == IDX_W'(DEPTH - 1)) ? where_rd : where_rd + 1'b1;
        end else begin
            look_calc = (where_rd == '0) ? where_rd : where_rd - 1'b1;
        end
    end

    // memory port selection
    always_comb begin
        value_re    = cmd.look || cmd.swap_rd;
        value_raddr = cmd.look ? look_calc : wm_reg;
        value_we    = cmd.swap_a || cmd.swap_b;
        value_waddr = cmd.swap_a ? wm_reg : look_reg;
        value_wdata = cmd.swap_a ? vb_reg : va_reg;

        where_re    = cmd.load_m || cmd.step || cmd.swap_a;
        dir_re      = cmd.load_m || cmd.step;
        if (cmd.load_m) begin
            walk_raddr = n_reg;
        end else if (cmd.step) begin
            walk_raddr = m_reg - 1'b1;
        end else begin
            walk_raddr = vb_reg;
        end
        where_we    = cmd.swap_b || cmd.swap_w;
        where_waddr = cmd.swap_b ? m_reg : vb_reg;
        where_wdata = cmd.swap_b ? where_rd : wm_reg;
    end

    // memory arrays
    always_ff @(posedge aclk) begin
        if (value_we) begin
            value_mem[value_waddr] <= value_wdata;
        end
        if (value_re) begin
            value_rdata_reg <= value_mem[value_raddr];
            value_raddr_reg <= value_raddr;
        end
        if (where_we) begin
            where_mem[where_waddr] <= where_wdata;
        end
        if (where_re) begin
            where_rdata_reg <= where_mem[walk_raddr];
            walk_raddr_reg  <= walk_raddr;
        end
        if (cmd.step) begin
            dir_mem[m_reg] <= !dir_m_reg;
        end
        if (dir_re) begin
            dir_rdata_reg <= dir_mem[walk_raddr];
        end
    end

    // written flags, cleared at once by reset and by a reload
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            value_vld_reg  <= '0;
            where_vld_reg  <= '0;
            dir_vld_reg    <= '0;
            value_rvld_reg <= 1'b0;
            where_rvld_reg <= 1'b0;
            dir_rvld_reg   <= 1'b0;
        end else begin
            if (restart_load) begin
                value_vld_reg <= '0;
                where_vld_reg <= '0;
                dir_vld_reg   <= '0;
            end else begin
                if (value_we) begin
                    value_vld_reg[value_waddr] <= 1'b1;
                end
                if (where_we) begin
                    where_vld_reg[where_waddr] <= 1'b1;
                end
                if (cmd.step) begin
                    dir_vld_reg[m_reg] <= 1'b1;
                end
            end
            if (value_re) begin
                value_rvld_reg <= value_vld_reg[value_raddr];
            end
            if (where_re) begin
                where_rvld_reg <= where_vld_reg[walk_raddr];
            end
            if (dir_re) begin
                dir_rvld_reg <= dir_vld_reg[walk_raddr];
            end
        end
    end

    // config register, sentinel value and exhausted flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_items_reg  <= asp_pkg::NCFG_W'(asp_pkg::N_ITEMS_RESET);
            fill_top_reg <= IDX_W'(RESET_N + 1);
            exh_reg      <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                n_items_reg <= cfg_wr_data;
            end
            if (restart_load) begin
                fill_top_reg <= n_act + 1'b1;
                exh_reg      <= 1'b0;
            end else if (cmd.set_exh) begin
                exh_reg <= 1'b1;
            end
        end
    end

    // request, walk and swap registers
    always_ff @(posedge aclk) begin
        if (cmd.take_req) begin
            n_reg    <= n_act;
            want_reg <= want_sat;
            cnt_reg  <= '0;
        end
        if (cmd.load_m) begin
            m_reg <= n_reg;
        end else if (cmd.step) begin
            m_reg <= m_reg - 1'b1;
        end
        if (cmd.look) begin
            wm_reg    <= where_rd;
            dir_m_reg <= dir_rd;
            look_reg  <= look_calc;
        end
        if (cmd.swap_rd) begin
            vb_reg <= value_rd;
        end
        if (cmd.swap_a) begin
            va_reg <= value_rd;
        end
        if (cmd.swap_w) begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.swap_w) begin
            out_first_reg  <= asp_pkg::POS_W'(wm_reg);
            out_second_reg <= asp_pkg::POS_W'(look_reg);
            out_pv_reg     <= 1'b1;
            out_last_reg   <= (cnt_reg + 1'b1) == want_reg;
            out_more_reg   <= 1'b1;
        end else if (cmd.out_none) begin
            out_first_reg  <= '0;
            out_second_reg <= '0;
            out_pv_reg     <= 1'b0;
            out_last_reg   <= 1'b1;
            out_more_reg   <= 1'b0;
        end
    end

    assign sts.req_bad   = req_bad;
    assign sts.exhausted = exh_reg;
    assign sts.found     = value_rd <= m_reg;
    assign sts.m_is_two  = m_reg == IDX_W'(2);
    assign sts.out_last  = out_last_reg;

    assign out_first      = out_first_reg;
    assign out_second     = out_second_reg;
    assign out_pair_valid = out_pv_reg;
    assign out_last       = out_last_reg;
    assign out_more       = out_more_reg;

`ifndef SYNTHESIS
    // the walk never goes below element 2
    a_walk_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.look || cmd.step) |-> (m_reg >= IDX_W'(2)))
        else $error("walk reached an element below 2");

    // an exhausted sequence stays exhausted until a reload
    a_exh_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (exh_reg && !restart_load) |=> exh_reg)
        else $error("exhausted flag dropped without a reload");
`endif

endmodule

`default_nettype wire

// File: hdl/asp_ctrl.sv
`default_nettype none

module asp_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    input  wire asp_pkg::asp_sts_t  sts,
    output asp_pkg::asp_cmd_t       cmd
);

    asp_pkg::asp_state_t state_reg;
    asp_pkg::asp_state_t state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= asp_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            asp_pkg::ST_IDLE: begin
                if (s_tvalid && aresetn) begin
                    cmd.take_req = 1'b1;
                    if (sts.req_bad) begin
                        cmd.out_none = 1'b1;
                        state_next   = asp_pkg::ST_OUT;
                    end else begin
                        state_next = asp_pkg::ST_ITER;
                    end
                end
            end
            asp_pkg::ST_ITER: begin
                if (sts.exhausted) begin
                    cmd.out_none = 1'b1;
                    state_next   = asp_pkg::ST_OUT;
                end else begin
                    cmd.load_m = 1'b1;
                    state_next = asp_pkg::ST_LOOK;
                end
            end
            asp_pkg::ST_LOOK: begin
                cmd.look   = 1'b1;
                state_next = asp_pkg::ST_CMP;
            end
            asp_pkg::ST_CMP: begin
                if (sts.found) begin
                    cmd.swap_rd = 1'b1;
                    state_next  = asp_pkg::ST_SWAP_A;
                end else begin
                    cmd.step = 1'b1;
                    if (sts.m_is_two) begin
                        cmd.set_exh  = 1'b1;
                        cmd.out_none = 1'b1;
                        state_next   = asp_pkg::ST_OUT;
                    end else begin
                        state_next = asp_pkg::ST_LOOK;
                    end
                end
            end
            asp_pkg::ST_SWAP_A: begin
                cmd.swap_a = 1'b1;
                state_next = asp_pkg::ST_SWAP_B;
            end
            asp_pkg::ST_SWAP_B: begin
                cmd.swap_b = 1'b1;
                state_next = asp_pkg::ST_SWAP_W;
            end
            asp_pkg::ST_SWAP_W: begin
                cmd.swap_w = 1'b1;
                state_next = asp_pkg::ST_OUT;
            end
            asp_pkg::ST_OUT: begin
                if (m_tready) begin
                    state_next = sts.out_last ? asp_pkg::ST_IDLE : asp_pkg::ST_ITER;
                end
            end
            default: begin
                state_next = asp_pkg::ST_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == asp_pkg::ST_IDLE) && aresetn;
    assign m_tvalid = (state_reg == asp_pkg::ST_OUT);

`ifndef SYNTHESIS
    // one request at a time: no new transaction right after one is taken
    a_one_req: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request taken while another is in progress");

    // a rejected request answers in the next cycle
    a_bad_answer: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && sts.req_bad) |=> (m_tvalid && sts.out_last))
        else $error("rejected request not answered at once");
`endif

endmodule

`default_nettype wire

// File: hdl/adjacent_swap_permutation_generator.sv
// Minimal-change permutation generator: each result is one neighbour swap
// in adjacent-transposition order over n_items elements.
// Config: cfg_wr_en/cfg_wr_data write n_items (2..MAX_ITEMS) while idle.
// Requests arrive on s_*: s_tuser is the restart flag (reload identity
// first), s_tdata[6:0] the number of pairs wanted (1..MAX_PAIRS).
// Results leave on m_*: m_tdata holds the two one-based positions, m_tuser
// the pair-valid and more-left flags, m_tlast marks the last result of the
// request. An exhausted sequence or a bad request gives one result with no
// pair.
// Timing: one request at a time. Each pair starts in ITER, then a downward
// walk inspects 1..n_items-1 elements through the registered reads of the
// permutation memories, a LOOK and a CMP state per element, then the swap
// writes run in SWAP_A, SWAP_B and SWAP_W, and the result waits in ST_OUT.
// A stalled receiver holds the result in the output register and the block
// waits; s_tready stays low until the last result of a request is taken.
// Reset loads the identity permutation for four items and n_items = 4;
// no clearing pass is needed.
`default_nettype none

module adjacent_swap_permutation_generator #(
    parameter int MAX_ITEMS = 32,
    parameter int MAX_PAIRS = 64
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [asp_pkg::NCFG_W-1:0]     cfg_wr_data,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [asp_pkg::S_TDATA_W-1:0]  s_tdata,   // pairs_wanted, pad
    input  wire logic                           s_tuser,   // restart
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic      [asp_pkg::M_TDATA_W-1:0]  m_tdata,   // first_pos, second_pos, pad
    output logic                                m_tlast,   // last_of_run
    output logic      [asp_pkg::M_TUSER_W-1:0]  m_tuser    // pair_valid, more_left
);

    asp_pkg::asp_cmd_t          cmd;
    asp_pkg::asp_sts_t          sts;
    logic [asp_pkg::POS_W-1:0]  out_first;
    logic [asp_pkg::POS_W-1:0]  out_second;
    logic                       out_pair_valid;
    logic                       out_more;

    // controller
    asp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath with the permutation memories
    asp_datapath #(
        .MAX_ITEMS (MAX_ITEMS),
        .MAX_PAIRS (MAX_PAIRS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_restart      (s_tuser),
        .s_pairs_wanted (s_tdata[asp_pkg::WANT_W-1:0]),
        .cmd            (cmd),
        .sts            (sts),
        .out_first      (out_first),
        .out_second     (out_second),
        .out_pair_valid (out_pair_valid),
        .out_last       (m_tlast),
        .out_more       (out_more)
    );

    // result packing
    assign m_tdata = {{(asp_pkg::M_TDATA_W - 2 * asp_pkg::POS_W){1'b0}},
                      out_second, out_first};
    assign m_tuser = {out_more, out_pair_valid};

`ifndef SYNTHESIS
    // a result without a pair ends the request and reports nothing left
    a_none_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tlast && !m_tuser[1]))
        else $error("result without a pair is not a final empty result");
`endif

endmodule

`default_nettype wire
